[design/vffi_pkg.sv]
// ----------------------------------------------------------------------------
// Floor friction integrator package
// Shared types, register indexes and small arithmetic helpers.
// ----------------------------------------------------------------------------
package vffi_pkg;

  // Register indexes of the configuration port.
  localparam logic [0:0] CFG_FLOOR_HEIGHT = 1'b0;
  localparam logic [0:0] CFG_TIME_STEP    = 1'b1;

  // Widest friction magnitude over the supported range of fraction bits.
  localparam int FR_MAX_W = 44;

  // Per-item context that travels down the pipeline.
  typedef struct packed {
    logic signed [31:0]  px;
    logic signed [31:0]  py;
    logic signed [31:0]  pz;
    logic signed [31:0]  vx;
    logic signed [31:0]  vy;
    logic signed [31:0]  vz;
    logic signed [31:0]  fx;
    logic signed [31:0]  fy;
    logic signed [31:0]  fz;
    logic [30:0]         mass;
    logic                on_floor;
    logic                fric;
    logic                stop;
    logic [FR_MAX_W-1:0] fr;
    logic [63:0]         hsq;
  } ctx_t;

  // Magnitude of a 32-bit signed value as an unsigned word.
  function automatic logic [31:0] mag32(logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

  // Saturate a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[design/vertex_floor_friction_integrator_top.sv]
// ----------------------------------------------------------------------------
// Vertex floor friction integrator
// done_o rises together with the result word; the depth of the pipeline is set
// by the three bit-serial divider pipelines and the square root pipeline.
// Throughput: one word per cycle; busy_o stays low and the receiver cannot stall.
// Reset: clears all valid bits; the floor height returns to 0 and time_step to 1092.
// ----------------------------------------------------------------------------
module vertex_floor_friction_integrator_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic signed [31:0] force_x_i,
  input  logic signed [31:0] force_y_i,
  input  logic signed [31:0] force_z_i,
  input  logic [30:0]        body_mass_i,
  input  logic [19:0]        friction_coeff_i,
  output logic               done_o,
  output logic signed [31:0] new_pos_x_o,
  output logic signed [31:0] new_pos_y_o,
  output logic signed [31:0] new_pos_z_o,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_y_o,
  output logic signed [31:0] new_vel_z_o,
  output logic signed [31:0] new_force_x_o,
  output logic signed [31:0] new_force_y_o,
  output logic signed [31:0] new_force_z_o,
  output logic               on_floor_o
);

  localparam int FR_W   = 51 - FRAC_BITS;
  localparam int FRDT_W = FR_W + 17;
  localparam int D1_W   = (FRDT_W > 48) ? FRDT_W : 48;
  localparam int D2_W   = FR_W + 32;
  localparam int D3_W   = 48;
  localparam int S3_W   = D1_W + 2;
  localparam int CTX_W  = $bits(vffi_pkg::ctx_t);
  localparam longint unsigned EPS_RAW = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned EPS     = (EPS_RAW < 64'd1) ? 64'd1 : EPS_RAW;
  localparam logic [63:0]     EPS_SQ  = 64'(EPS * EPS);

  // Configuration registers.
  logic signed [31:0] floor_q;
  logic [16:0]        dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= '0;
      dt_q    <= 17'd1092;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vffi_pkg::CFG_FLOOR_HEIGHT: floor_q <= cfg_data_i;
        vffi_pkg::CFG_TIME_STEP:    dt_q    <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // Valid bits of the local stages.
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;
  logic done_q;
  logic vd1, vsq, vd2, vd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      v9_q   <= 1'b0;
      v10_q  <= 1'b0;
      v11_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= start_i & ~busy_o;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= vd1;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= vsq;
      v7_q   <= v6_q;
      v8_q   <= vd2;
      v9_q   <= v8_q;
      v10_q  <= vd3;
      v11_q  <= v10_q;
      done_q <= v11_q;
    end
  end

  // Stage 0: capture the word; a zero mass counts as the smallest mass.
  vffi_pkg::ctx_t c0_q;
  logic [19:0]    mu0_q;

  always_ff @(posedge clk_i) begin
    c0_q.px       <= pos_x_i;
    c0_q.py       <= pos_y_i;
    c0_q.pz       <= pos_z_i;
    c0_q.vx       <= vel_x_i;
    c0_q.vy       <= vel_y_i;
    c0_q.vz       <= vel_z_i;
    c0_q.fx       <= force_x_i;
    c0_q.fy       <= force_y_i;
    c0_q.fz       <= force_z_i;
    c0_q.mass     <= (body_mass_i == '0) ? 31'd1 : body_mass_i;
    c0_q.on_floor <= 1'b0;
    c0_q.fric     <= 1'b0;
    c0_q.stop     <= 1'b0;
    c0_q.fr       <= '0;
    c0_q.hsq      <= '0;
    mu0_q         <= friction_coeff_i;
  end

  // Stage 1: floor clamp and the first products.
  vffi_pkg::ctx_t c1_d, c1_q;
  logic [50:0]    fr1_d, fr1_q;
  logic [47:0]    fxdt1_d, fxdt1_q, fzdt1_d, fzdt1_q;
  logic [63:0]    vx2_1_d, vx2_1_q, vz2_1_d, vz2_1_q;

  always_comb begin
    c1_d          = c0_q;
    c1_d.on_floor = c0_q.py < floor_q;
    if (c1_d.on_floor) begin
      c1_d.py = floor_q;
      if (c0_q.vy < 0) begin
        c1_d.vy = '0;
      end
    end
    c1_d.fric = c1_d.on_floor & c0_q.fy[31];
    fr1_d     = 51'(vffi_pkg::mag32(c0_q.fy)) * 51'(mu0_q);
    fxdt1_d   = 48'(vffi_pkg::mag32(c0_q.fx)) * 48'(dt_q);
    fzdt1_d   = 48'(vffi_pkg::mag32(c0_q.fz)) * 48'(dt_q);
    vx2_1_d   = vffi_pkg::mag32(c0_q.vx) * vffi_pkg::mag32(c0_q.vx);
    vz2_1_d   = vffi_pkg::mag32(c0_q.vz) * vffi_pkg::mag32(c0_q.vz);
  end

  always_ff @(posedge clk_i) begin
    c1_q    <= c1_d;
    fr1_q   <= fr1_d;
    fxdt1_q <= fxdt1_d;
    fzdt1_q <= fzdt1_d;
    vx2_1_q <= vx2_1_d;
    vz2_1_q <= vz2_1_d;
  end

  // Stage 2: friction magnitude, its tick product and the squared speed.
  vffi_pkg::ctx_t    c2_d, c2_q;
  logic [FR_W-1:0]   frv2;
  logic [FRDT_W-1:0] frdt2_d, frdt2_q;

  always_comb begin
    frv2     = fr1_q[50 -: FR_W];
    c2_d     = c1_q;
    c2_d.fr  = vffi_pkg::FR_MAX_W'(frv2);
    c2_d.hsq = vx2_1_q + vz2_1_q;
    frdt2_d  = frv2 * dt_q;
  end

  logic [47:0] fxdt2_q, fzdt2_q;

  always_ff @(posedge clk_i) begin
    c2_q    <= c2_d;
    frdt2_q <= frdt2_d;
    fxdt2_q <= fxdt1_q;
    fzdt2_q <= fzdt1_q;
  end

  // First divider set: tick velocity change and tick friction.
  logic [D1_W-1:0]  q1x, q1z, q1f;
  logic [CTX_W-1:0] tag1;
  vffi_pkg::ctx_t   cd1;

  vffi_div #(.NW(D1_W), .DW(31), .TAG_W(CTX_W)) u_div1_x (
    .clk_i, .rst_ni, .valid_i(v2_q), .num_i(D1_W'(fxdt2_q)), .den_i(c2_q.mass),
    .tag_i(c2_q), .valid_o(vd1), .quo_o(q1x), .tag_o(tag1)
  );
  vffi_div #(.NW(D1_W), .DW(31), .TAG_W(1)) u_div1_z (
    .clk_i, .rst_ni, .valid_i(v2_q), .num_i(D1_W'(fzdt2_q)), .den_i(c2_q.mass),
    .tag_i(1'b0), .valid_o(), .quo_o(q1z), .tag_o()
  );
  vffi_div #(.NW(D1_W), .DW(31), .TAG_W(1)) u_div1_f (
    .clk_i, .rst_ni, .valid_i(v2_q), .num_i(D1_W'(frdt2_q)), .den_i(c2_q.mass),
    .tag_i(1'b0), .valid_o(), .quo_o(q1f), .tag_o()
  );

  assign cd1 = vffi_pkg::ctx_t'(tag1);

  // Stage 3: clamp the tick velocity and the tick friction.
  logic signed [S3_W-1:0] sx3, sz3;
  logic [S3_W-1:0]        ax3, az3;
  logic [31:0]            sxm3_d, sxm3_q, szm3_d, szm3_q, stf3_d, stf3_q;
  vffi_pkg::ctx_t         c3_q;

  always_comb begin
    sx3 = cd1.fx[31] ? (S3_W'(cd1.vx) - $signed({2'b00, q1x}))
                     : (S3_W'(cd1.vx) + $signed({2'b00, q1x}));
    sz3 = cd1.fz[31] ? (S3_W'(cd1.vz) - $signed({2'b00, q1z}))
                     : (S3_W'(cd1.vz) + $signed({2'b00, q1z}));
    ax3 = sx3[S3_W-1] ? S3_W'(-sx3) : S3_W'(sx3);
    az3 = sz3[S3_W-1] ? S3_W'(-sz3) : S3_W'(sz3);
    sxm3_d = (ax3 > S3_W'(64'h8000_0000)) ? 32'h8000_0000 : ax3[31:0];
    szm3_d = (az3 > S3_W'(64'h8000_0000)) ? 32'h8000_0000 : az3[31:0];
    stf3_d = (q1f > D1_W'(64'hFFFF_FFFF)) ? 32'hFFFF_FFFF : q1f[31:0];
  end

  always_ff @(posedge clk_i) begin
    c3_q   <= cd1;
    sxm3_q <= sxm3_d;
    szm3_q <= szm3_d;
    stf3_q <= stf3_d;
  end

  // Stage 4: squares for the stop test.
  logic [63:0]    sx2_4_q, sz2_4_q, stf2_4_q;
  vffi_pkg::ctx_t c4_q;

  always_ff @(posedge clk_i) begin
    c4_q     <= c3_q;
    sx2_4_q  <= sxm3_q * sxm3_q;
    sz2_4_q  <= szm3_q * szm3_q;
    stf2_4_q <= stf3_q * stf3_q;
  end

  // Stage 5: friction halts the motion within the tick, or the speed is tiny.
  vffi_pkg::ctx_t c5_d, c5_q;
  logic [63:0]    svsq5;

  always_comb begin
    svsq5     = sx2_4_q + sz2_4_q;
    c5_d      = c4_q;
    c5_d.stop = c4_q.fric & ((svsq5 <= stf2_4_q) | (c4_q.hsq < EPS_SQ));
  end

  always_ff @(posedge clk_i) begin
    c5_q <= c5_d;
  end

  // Horizontal speed.
  logic [31:0]      len_s;
  logic [CTX_W-1:0] tag_s;
  vffi_pkg::ctx_t   cs;

  vffi_isqrt #(.TAG_W(CTX_W)) u_isqrt (
    .clk_i, .rst_ni, .valid_i(v5_q), .rad_i(c5_q.hsq), .tag_i(c5_q),
    .valid_o(vsq), .root_o(len_s), .tag_o(tag_s)
  );

  assign cs = vffi_pkg::ctx_t'(tag_s);

  // Stage 6: partial products of friction times each speed component.
  localparam int HI_W = vffi_pkg::FR_MAX_W - 32;

  logic [63:0]      lox6_q, loz6_q;
  logic [HI_W+31:0] hix6_q, hiz6_q;
  logic [31:0]      len6_q;
  vffi_pkg::ctx_t   c6_q;

  always_ff @(posedge clk_i) begin
    c6_q   <= cs;
    len6_q <= len_s;
    lox6_q <= cs.fr[31:0] * vffi_pkg::mag32(cs.vx);
    loz6_q <= cs.fr[31:0] * vffi_pkg::mag32(cs.vz);
    hix6_q <= cs.fr[vffi_pkg::FR_MAX_W-1:32] * vffi_pkg::mag32(cs.vx);
    hiz6_q <= cs.fr[vffi_pkg::FR_MAX_W-1:32] * vffi_pkg::mag32(cs.vz);
  end

  // Stage 7: combine the partial products.
  localparam int P7_W = HI_W + 64;

  logic [P7_W-1:0] px7, pz7;
  logic [D2_W-1:0] nx7_q, nz7_q;
  logic [31:0]     len7_q;
  vffi_pkg::ctx_t  c7_q;

  always_comb begin
    px7 = {hix6_q, 32'h0} + P7_W'(lox6_q);
    pz7 = {hiz6_q, 32'h0} + P7_W'(loz6_q);
  end

  always_ff @(posedge clk_i) begin
    c7_q   <= c6_q;
    len7_q <= len6_q;
    nx7_q  <= px7[D2_W-1:0];
    nz7_q  <= pz7[D2_W-1:0];
  end

  // Second divider set: friction split along the direction of motion.
  logic [D2_W-1:0]  dx2, dz2;
  logic [CTX_W-1:0] tag2;
  vffi_pkg::ctx_t   cd2;

  vffi_div #(.NW(D2_W), .DW(32), .TAG_W(CTX_W)) u_div2_x (
    .clk_i, .rst_ni, .valid_i(v7_q), .num_i(nx7_q), .den_i(len7_q),
    .tag_i(c7_q), .valid_o(vd2), .quo_o(dx2), .tag_o(tag2)
  );
  vffi_div #(.NW(D2_W), .DW(32), .TAG_W(1)) u_div2_z (
    .clk_i, .rst_ni, .valid_i(v7_q), .num_i(nz7_q), .den_i(len7_q),
    .tag_i(1'b0), .valid_o(), .quo_o(dz2), .tag_o()
  );

  assign cd2 = vffi_pkg::ctx_t'(tag2);

  // Stage 8: apply the friction decision to velocity and force.
  vffi_pkg::ctx_t     c8_d, c8_q;
  logic signed [63:0] dxs8, dzs8;

  always_comb begin
    dxs8 = $signed(64'(dx2));
    dzs8 = $signed(64'(dz2));
    c8_d = cd2;
    if (cd2.fric) begin
      if (cd2.stop) begin
        c8_d.vx = '0;
        c8_d.vz = '0;
        c8_d.fx = '0;
        c8_d.fz = '0;
      end else begin
        c8_d.fx = vffi_pkg::sat32(cd2.vx[31] ? (64'(cd2.fx) + dxs8) : (64'(cd2.fx) - dxs8));
        c8_d.fz = vffi_pkg::sat32(cd2.vz[31] ? (64'(cd2.fz) + dzs8) : (64'(cd2.fz) - dzs8));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c8_q <= c8_d;
  end

  // Stage 9: force times dt for the velocity update.
  logic [D3_W-1:0] fxdt9_q, fydt9_q, fzdt9_q;
  vffi_pkg::ctx_t  c9_q;

  always_ff @(posedge clk_i) begin
    c9_q    <= c8_q;
    fxdt9_q <= D3_W'(vffi_pkg::mag32(c8_q.fx)) * D3_W'(dt_q);
    fydt9_q <= D3_W'(vffi_pkg::mag32(c8_q.fy)) * D3_W'(dt_q);
    fzdt9_q <= D3_W'(vffi_pkg::mag32(c8_q.fz)) * D3_W'(dt_q);
  end

  // Third divider set: velocity change over mass.
  logic [D3_W-1:0]  q3x, q3y, q3z;
  logic [CTX_W-1:0] tag3;
  vffi_pkg::ctx_t   cd3;

  vffi_div #(.NW(D3_W), .DW(31), .TAG_W(CTX_W)) u_div3_x (
    .clk_i, .rst_ni, .valid_i(v9_q), .num_i(fxdt9_q), .den_i(c9_q.mass),
    .tag_i(c9_q), .valid_o(vd3), .quo_o(q3x), .tag_o(tag3)
  );
  vffi_div #(.NW(D3_W), .DW(31), .TAG_W(1)) u_div3_y (
    .clk_i, .rst_ni, .valid_i(v9_q), .num_i(fydt9_q), .den_i(c9_q.mass),
    .tag_i(1'b0), .valid_o(), .quo_o(q3y), .tag_o()
  );
  vffi_div #(.NW(D3_W), .DW(31), .TAG_W(1)) u_div3_z (
    .clk_i, .rst_ni, .valid_i(v9_q), .num_i(fzdt9_q), .den_i(c9_q.mass),
    .tag_i(1'b0), .valid_o(), .quo_o(q3z), .tag_o()
  );

  assign cd3 = vffi_pkg::ctx_t'(tag3);

  // Stage 10: velocity update, truncated toward zero, saturated.
  vffi_pkg::ctx_t     c10_d, c10_q;
  logic signed [63:0] qx10, qy10, qz10;

  always_comb begin
    qx10     = $signed(64'(q3x));
    qy10     = $signed(64'(q3y));
    qz10     = $signed(64'(q3z));
    c10_d    = cd3;
    c10_d.vx = vffi_pkg::sat32(cd3.fx[31] ? (64'(cd3.vx) - qx10) : (64'(cd3.vx) + qx10));
    c10_d.vy = vffi_pkg::sat32(cd3.fy[31] ? (64'(cd3.vy) - qy10) : (64'(cd3.vy) + qy10));
    c10_d.vz = vffi_pkg::sat32(cd3.fz[31] ? (64'(cd3.vz) - qz10) : (64'(cd3.vz) + qz10));
  end

  always_ff @(posedge clk_i) begin
    c10_q <= c10_d;
  end

  // Stage 11: velocity times dt.
  logic signed [49:0] pdx11_q, pdy11_q, pdz11_q;
  logic signed [17:0] dts;
  vffi_pkg::ctx_t     c11_q;

  assign dts = $signed({1'b0, dt_q});

  always_ff @(posedge clk_i) begin
    c11_q   <= c10_q;
    pdx11_q <= c10_q.vx * dts;
    pdy11_q <= c10_q.vy * dts;
    pdz11_q <= c10_q.vz * dts;
  end

  // Stage 12: position update with floor rounding, into the output word.
  vffi_pkg::ctx_t c12_d, c12_q;

  always_comb begin
    c12_d    = c11_q;
    c12_d.px = vffi_pkg::sat32(64'(c11_q.px) + 64'(pdx11_q >>> FRAC_BITS));
    c12_d.py = vffi_pkg::sat32(64'(c11_q.py) + 64'(pdy11_q >>> FRAC_BITS));
    c12_d.pz = vffi_pkg::sat32(64'(c11_q.pz) + 64'(pdz11_q >>> FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    c12_q <= c12_d;
  end

  assign done_o        = done_q;
  assign new_pos_x_o   = c12_q.px;
  assign new_pos_y_o   = c12_q.py;
  assign new_pos_z_o   = c12_q.pz;
  assign new_vel_x_o   = c12_q.vx;
  assign new_vel_y_o   = c12_q.vy;
  assign new_vel_z_o   = c12_q.vz;
  assign new_force_x_o = c12_q.fx;
  assign new_force_y_o = c12_q.fy;
  assign new_force_z_o = c12_q.fz;
  assign on_floor_o    = c12_q.on_floor;

endmodule

[design/vffi_div.sv]
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with a tag carried along.
// ----------------------------------------------------------------------------
module vffi_div #(
  parameter int NW    = 48,
  parameter int DW    = 31,
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NW-1:0]    num_i,
  input  logic [DW-1:0]    den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [NW-1:0]    quo_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [NW:0]       vld_q;
  logic [NW-1:0]     num_q [NW+1];
  logic [NW-1:0]     quo_q [NW+1];
  logic [DW-1:0]     rem_q [NW+1];
  logic [DW-1:0]     den_q [NW+1];
  logic [TAG_W-1:0]  tag_q [NW+1];

  // Valid bits shift along with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NW-1:0], valid_i};
    end
  end

  // Entry stage.
  always_ff @(posedge clk_i) begin
    num_q[0] <= num_i;
    quo_q[0] <= '0;
    rem_q[0] <= '0;
    den_q[0] <= den_i;
    tag_q[0] <= tag_i;
  end

  // One compare and subtract per stage, most significant bit first.
  for (genvar s = 0; s < NW; s++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_q[s], num_q[s][NW-1-s]};
    assign ge    = trial >= {1'b0, den_q[s]};
    assign diff  = trial - {1'b0, den_q[s]};

    always_ff @(posedge clk_i) begin
      num_q[s+1] <= num_q[s];
      quo_q[s+1] <= {quo_q[s][NW-2:0], ge};
      rem_q[s+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      den_q[s+1] <= den_q[s];
      tag_q[s+1] <= tag_q[s];
    end
  end

  assign valid_o = vld_q[NW];
  assign quo_o   = quo_q[NW];
  assign tag_o   = tag_q[NW];

endmodule

[design/vffi_isqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit word, one root bit per stage.
// ----------------------------------------------------------------------------
module vffi_isqrt #(
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [63:0]      rad_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [31:0]      root_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int NS = 32;

  logic [NS:0]      vld_q;
  logic [63:0]      rad_q  [NS+1];
  logic [33:0]      rem_q  [NS+1];
  logic [31:0]      root_q [NS+1];
  logic [TAG_W-1:0] tag_q  [NS+1];

  // Valid bits shift along with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-1:0], valid_i};
    end
  end

  // Entry stage.
  always_ff @(posedge clk_i) begin
    rad_q[0]  <= rad_i;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    tag_q[0]  <= tag_i;
  end

  // Each stage brings down two radicand bits and tries the next root bit.
  for (genvar s = 0; s < NS; s++) begin : g_step
    logic [35:0] shifted;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    assign shifted = {rem_q[s], rad_q[s][63-2*s -: 2]};
    assign trial   = {2'b00, root_q[s], 2'b01};
    assign ge      = shifted >= trial;
    assign diff    = shifted - trial;

    always_ff @(posedge clk_i) begin
      rad_q[s+1]  <= rad_q[s];
      rem_q[s+1]  <= ge ? diff[33:0] : shifted[33:0];
      root_q[s+1] <= {root_q[s][30:0], ge};
      tag_q[s+1]  <= tag_q[s];
    end
  end

  assign valid_o = vld_q[NS];
  assign root_o  = root_q[NS];
  assign tag_o   = tag_q[NS];

endmodule
